[hdl/merge_sort_engine_assert.svh]
// assertion macros for the merge sort engine
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define MSE_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define MSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mse_pkg.sv]
// shared constants and types of the merge sort engine
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

    localparam int MAX_ITEMS_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_RUN,
        ST_MERGE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[hdl/mse_ram.sv]
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module mse_ram #(
    parameter int WIDTH = mse_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = mse_pkg::MAX_ITEMS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr0,
    input  wire logic [AW-1:0]    raddr1,
    output logic      [WIDTH-1:0] rdata0,
    output logic      [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

[hdl/merge_sort_engine.sv]
// top level of the merge sort engine: load, bottom-up merge passes, drain
`timescale 1ns / 1ps
`default_nettype none
`include "merge_sort_engine_assert.svh"

// merge_sort_engine
// input channel s_*: one signed value per word, s_tlast closes the set.
// words arriving while the store holds MAX_ITEMS values are dropped and every
// result of that set carries m_tuser = 1 (overflow).
// result channel m_*: the stored values in ascending order, ties in arrival
// order, m_tlast on the final one.
// loaded words are written to store a in arrival order. after the closing
// word the set is sorted by bottom-up merge passes between two rams (store a,
// store b), one merged element per cycle while a run pair is merged; there
// are ceil(log2(n)) passes. each result is read from the ram and then passes
// through the output register; a new ram read waits until the previous word
// has landed in the output register.
// s_tready is high only while loading; it rises again as soon as the final
// result sits in the output register, even while that result still waits.
// when the receiver stalls, the output register holds its word and no new
// ram read is issued. aresetn (synchronous, active low) empties the set,
// clears the overflow flag and drops any pending result; ram contents are
// left as they are and need no clearing pass.
module merge_sort_engine #(
    parameter int MAX_ITEMS  = mse_pkg::MAX_ITEMS_DEF,
    parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input word
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]   s_tdata,  // [DATA_WIDTH-1:0] value
    input  wire logic                              s_tlast,  // last of the set
    // result word
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata,  // [DATA_WIDTH-1:0] sorted_value
    output logic                                   m_tlast,  // last_res
    output logic                                   m_tuser   // [0] overflowed
);

    localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    // indexes and run bounds, with headroom for lo + 2 * width
    localparam int SW  = CW + 2;

    mse_pkg::state_t state_reg, state_next;

    logic [CW-1:0]         count_reg, count_next;
    logic                  drop_reg, drop_next;
    logic                  src_reg, src_next;    // 1: store b holds the source runs
    logic [SW-1:0]         width_reg, width_next;
    logic [SW-1:0]         lo_reg, lo_next;
    logic [SW-1:0]         mid_reg, mid_next;
    logic [SW-1:0]         hi_reg, hi_next;
    logic [SW-1:0]         i_reg, i_next;
    logic [SW-1:0]         j_reg, j_next;
    logic [SW-1:0]         k_reg, k_next;
    logic                  pend_reg, pend_next;  // ram read for the output in flight
    logic                  pend_last_reg, pend_last_next;
    logic                  mv_reg, mv_next;
    logic [DATA_WIDTH-1:0] md_reg, md_next;
    logic                  ml_reg, ml_next;
    logic                  mu_reg, mu_next;

    // ram ports
    logic                  a_we, b_we;
    logic [AW-1:0]         wr_addr, raddr0, raddr1;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] a_rd0, a_rd1, b_rd0, b_rd1;

    logic                  s_accept, m_accept;
    logic [SW-1:0]         n_ext;
    logic [DATA_WIDTH-1:0] head_i, head_j;
    logic                  take_i;
    logic                  run_done;
    logic [SW-1:0]         mid_c, hi_c, i_adv, j_adv;

    mse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store_a (
        .clk    (aclk),
        .we     (a_we),
        .waddr  (wr_addr),
        .wdata  (wr_data),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (a_rd0),
        .rdata1 (a_rd1)
    );

    mse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store_b (
        .clk    (aclk),
        .we     (b_we),
        .waddr  (wr_addr),
        .wdata  (wr_data),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (b_rd0),
        .rdata1 (b_rd1)
    );

    assign s_tready = (state_reg == mse_pkg::ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = mv_reg && m_tready;

    assign m_tvalid = mv_reg;
    assign m_tdata  = TDW'(md_reg);
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    assign n_ext = SW'(count_reg);

    // run heads: port 0 follows i, port 1 follows j
    assign head_i = src_reg ? b_rd0 : a_rd0;
    assign head_j = src_reg ? b_rd1 : a_rd1;

    // left run wins ties, an exhausted run never wins
    assign take_i = (i_reg < mid_reg) &&
                    ((j_reg >= hi_reg) || ($signed(head_i) <= $signed(head_j)));
    assign i_adv    = i_reg + SW'(take_i);
    assign j_adv    = j_reg + SW'(!take_i);
    assign run_done = ((k_reg + SW'(1)) == hi_reg);

    // bounds of the next run pair, clipped to the set size
    always_comb begin
        mid_c = lo_reg + width_reg;
        if (mid_c > n_ext) begin
            mid_c = n_ext;
        end
        hi_c = lo_reg + (width_reg << 1);
        if (hi_c > n_ext) begin
            hi_c = n_ext;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mse_pkg::ST_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = mse_pkg::ST_CHECK;
                end
            end
            mse_pkg::ST_CHECK: begin
                // another pass while runs are shorter than the set
                if (width_reg < n_ext) begin
                    state_next = mse_pkg::ST_RUN;
                end else begin
                    state_next = mse_pkg::ST_OUT;
                end
            end
            mse_pkg::ST_RUN: begin
                state_next = mse_pkg::ST_MERGE;
            end
            mse_pkg::ST_MERGE: begin
                if (run_done) begin
                    if (hi_reg == n_ext) begin
                        state_next = mse_pkg::ST_CHECK;
                    end else begin
                        state_next = mse_pkg::ST_RUN;
                    end
                end
            end
            mse_pkg::ST_OUT: begin
                if (pend_reg && pend_last_reg) begin
                    state_next = mse_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = mse_pkg::ST_LOAD;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        src_next       = src_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        mv_next        = mv_reg;
        md_next        = md_reg;
        ml_next        = ml_reg;
        mu_next        = mu_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = s_tdata[DATA_WIDTH-1:0];
        raddr0         = i_reg[AW-1:0];
        raddr1         = j_reg[AW-1:0];

        if (m_accept) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            mse_pkg::ST_LOAD: begin
                if (s_accept) begin
                    if (count_reg < CW'(MAX_ITEMS)) begin
                        a_we       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast) begin
                        width_next = SW'(1);
                        src_next   = 1'b0;
                    end
                end
            end
            mse_pkg::ST_CHECK: begin
                lo_next = '0;
                k_next  = '0;
            end
            mse_pkg::ST_RUN: begin
                i_next   = lo_reg;
                j_next   = mid_c;
                mid_next = mid_c;
                hi_next  = hi_c;
                k_next   = lo_reg;
                raddr0   = lo_reg[AW-1:0];
                raddr1   = mid_c[AW-1:0];
            end
            mse_pkg::ST_MERGE: begin
                wr_addr = k_reg[AW-1:0];
                wr_data = take_i ? head_i : head_j;
                a_we    = src_reg;
                b_we    = !src_reg;
                i_next  = i_adv;
                j_next  = j_adv;
                k_next  = k_reg + SW'(1);
                // fetch the new heads so they are ready next cycle
                raddr0  = i_adv[AW-1:0];
                raddr1  = j_adv[AW-1:0];
                if (run_done) begin
                    lo_next = hi_reg;
                    if (hi_reg == n_ext) begin
                        width_next = width_reg << 1;
                        src_next   = !src_reg;
                    end
                end
            end
            mse_pkg::ST_OUT: begin
                raddr0 = k_reg[AW-1:0];
                // read only when the output register is free by the next edge
                if ((k_reg < n_ext) && !pend_reg && (!mv_reg || m_tready)) begin
                    pend_next      = 1'b1;
                    pend_last_next = ((k_reg + SW'(1)) == n_ext);
                    k_next         = k_reg + SW'(1);
                end
                if (pend_reg && pend_last_reg) begin
                    count_next = '0;
                    drop_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // ram word lands in the output register
        if (pend_reg) begin
            mv_next = 1'b1;
            md_next = head_i;
            ml_next = pend_last_reg;
            mu_next = drop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mse_pkg::ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg       <= src_next;
        width_reg     <= width_next;
        lo_reg        <= lo_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        pend_last_reg <= pend_last_next;
        md_reg        <= md_next;
        ml_reg        <= ml_next;
        mu_reg        <= mu_next;
    end

    // a ram word for the output never arrives while the register is full
    `MSE_ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, pend_reg, !mv_reg, "output word overwritten")

    // merge write index stays inside the current run pair
    `MSE_ASSERT_IMPLY(a_k_in_run, aclk, aresetn, state_reg == mse_pkg::ST_MERGE, k_reg < hi_reg, "merge index past run end")

    // every merged word consumed exactly one head
    `MSE_ASSERT_IMPLY(a_k_tracks_heads, aclk, aresetn, state_reg == mse_pkg::ST_MERGE, (k_reg + mid_reg) == (i_reg + j_reg), "merge heads out of step")

    // a closed set is never empty
    `MSE_ASSERT_NEXT(a_set_not_empty, aclk, aresetn, s_accept && s_tlast, count_reg != '0, "empty set closed")

endmodule

`default_nettype wire
